/* src/sccs_pkg.sv */
// ----------------------------------------------------------------------------
// sccs_pkg
// Types, byte codes and command tables shared by the capture sequencer.
// ----------------------------------------------------------------------------
package sccs_pkg;

  // Byte source and destination codes
  localparam logic SRC_CAMERA  = 1'b0;
  localparam logic SRC_HOST    = 1'b1;
  localparam logic DEST_CAMERA = 1'b0;
  localparam logic DEST_HOST   = 1'b1;

  // Received byte codes
  localparam logic [7:0] HOST_CAPTURE = 8'h63;
  localparam logic [7:0] IMG_START    = 8'hFF;
  localparam logic [7:0] IMG_END_HI   = 8'hD9;
  localparam logic [7:0] IMG_END_LO   = 8'h76;

  // Command bytes
  localparam logic [7:0] CAM_SYNC     = 8'h56;
  localparam logic [7:0] CAM_SERIAL   = 8'h00;
  localparam logic [7:0] OP_FBUF_CTRL = 8'h36;
  localparam logic [7:0] OP_FBUF_LEN  = 8'h34;
  localparam logic [7:0] OP_READ_FBUF = 8'h32;
  localparam logic [7:0] LEN_ONE      = 8'h01;
  localparam logic [7:0] LEN_READ     = 8'h0C;
  localparam logic [7:0] ARG_RESUME   = 8'h03;
  localparam logic [7:0] ARG_STOP     = 8'h00;
  localparam logic [7:0] READ_MODE    = 8'h0A;
  localparam logic [7:0] READ_DELAY   = 8'h0A;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  // Reply counts that start the next command
  localparam logic [3:0] IDLE_REPLIES_DONE = 4'd3;
  localparam logic [3:0] SHOT_REPLIES_DONE = 4'd5;
  localparam logic [3:0] SIZE_REPLIES_DONE = 4'd9;
  localparam logic [3:0] COUNT_MAX         = 4'd15;

  // Positions of the size bytes within the size query reply
  localparam logic [3:0] SIZE_HI_POS = 4'd7;
  localparam logic [3:0] SIZE_LO_POS = 4'd8;

  // Last byte index of each command
  localparam logic [3:0] SHORT_CMD_LAST = 4'd4;
  localparam logic [3:0] READ_CMD_LAST  = 4'd15;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_IDLE,
    PH_SHOT,
    PH_SIZE
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_IDLE,
    CMD_SHOT,
    CMD_SIZE,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  // One classified input transaction: an optional host-bound byte, then
  // an optional camera command
  typedef struct packed {
    logic       fwd;
    logic [7:0] fwd_byte;
    cmd_t       cmd;
    logic [7:0] size_hi;
    logic [7:0] size_lo;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 4'd1;
  endfunction

  function automatic logic [3:0] cmd_last_idx(input cmd_t c);
    cmd_last_idx = (c == CMD_READ) ? READ_CMD_LAST : SHORT_CMD_LAST;
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [3:0] idx,
                                          input logic [7:0] size_hi,
                                          input logic [7:0] size_lo);
    logic [7:0] op;
    logic [7:0] arg;
    op  = OP_FBUF_CTRL;
    arg = ARG_STOP;
    unique case (c)
      CMD_IDLE: begin
        arg = ARG_RESUME;
      end
      CMD_SIZE: begin
        op = OP_FBUF_LEN;
      end
      default: begin
      end
    endcase
    if (c == CMD_READ) begin
      unique case (idx)
        4'd0:    cmd_byte = CAM_SYNC;
        4'd2:    cmd_byte = OP_READ_FBUF;
        4'd3:    cmd_byte = LEN_READ;
        4'd5:    cmd_byte = READ_MODE;
        4'd12:   cmd_byte = size_hi;
        4'd13:   cmd_byte = size_lo;
        4'd15:   cmd_byte = READ_DELAY;
        default: cmd_byte = BYTE_ZERO;
      endcase
    end else begin
      unique case (idx)
        4'd0:    cmd_byte = CAM_SYNC;
        4'd1:    cmd_byte = CAM_SERIAL;
        4'd2:    cmd_byte = op;
        4'd3:    cmd_byte = LEN_ONE;
        default: cmd_byte = arg;
      endcase
    end
  endfunction

endpackage

/* src/sccs_front.sv */
// ----------------------------------------------------------------------------
// sccs_front
// Accepts received bytes, tracks the capture phases and classifies each
// transaction into a job for the back end.
// ----------------------------------------------------------------------------
module sccs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sccs_pkg::in_item_t in_data,
  input  sccs_pkg::q_stat_t q_stat,
  output logic              q_push,
  output sccs_pkg::job_t    q_job
);

  sccs_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] idle_rep_r, idle_rep_nxt;
  logic [3:0] shot_rep_r, shot_rep_nxt;
  logic [3:0] size_rep_r, size_rep_nxt;
  logic [3:0] store_idx_r, store_idx_nxt;
  logic       capture_size_r, capture_size_nxt;
  logic       reading_r, reading_nxt;
  logic       started_r, started_nxt;
  logic       saw_end_r, saw_end_nxt;
  logic [7:0] size_hi_r, size_hi_nxt;
  logic [7:0] size_lo_r, size_lo_nxt;
  logic       accept;
  logic       fwd;
  sccs_pkg::cmd_t cmd;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    phase_nxt        = phase_r;
    idle_rep_nxt     = idle_rep_r;
    shot_rep_nxt     = shot_rep_r;
    size_rep_nxt     = size_rep_r;
    store_idx_nxt    = store_idx_r;
    capture_size_nxt = capture_size_r;
    reading_nxt      = reading_r;
    started_nxt      = started_r;
    saw_end_nxt      = saw_end_r;
    size_hi_nxt      = size_hi_r;
    size_lo_nxt      = size_lo_r;
    fwd              = 1'b0;
    cmd              = sccs_pkg::CMD_NONE;

    if (in_data.action == sccs_pkg::SRC_HOST) begin
      if (in_data.rx_byte == sccs_pkg::HOST_CAPTURE) begin
        size_hi_nxt   = sccs_pkg::BYTE_ZERO;
        size_lo_nxt   = sccs_pkg::BYTE_ZERO;
        phase_nxt     = sccs_pkg::PH_IDLE;
        idle_rep_nxt  = '0;
        store_idx_nxt = '0;
        reading_nxt   = 1'b0;
        started_nxt   = 1'b0;
        cmd           = sccs_pkg::CMD_IDLE;
      end
    end else begin
      unique case (phase_r)
        sccs_pkg::PH_IDLE: idle_rep_nxt = sccs_pkg::sat_inc(idle_rep_r);
        sccs_pkg::PH_SHOT: shot_rep_nxt = sccs_pkg::sat_inc(shot_rep_r);
        sccs_pkg::PH_SIZE: size_rep_nxt = sccs_pkg::sat_inc(size_rep_r);
        default: begin
        end
      endcase
      // Only the two size bytes of the stored reply are ever read back
      if (capture_size_r) begin
        if (store_idx_r == sccs_pkg::SIZE_HI_POS) begin
          size_hi_nxt = in_data.rx_byte;
        end
        if (store_idx_r == sccs_pkg::SIZE_LO_POS) begin
          size_lo_nxt = in_data.rx_byte;
        end
        store_idx_nxt = sccs_pkg::sat_inc(store_idx_r);
      end
      if (in_data.rx_byte == sccs_pkg::IMG_START) begin
        started_nxt = 1'b1;
      end
      priority if (in_data.rx_byte == sccs_pkg::IMG_END_HI) begin
        saw_end_nxt = 1'b1;
      end else if (in_data.rx_byte == sccs_pkg::IMG_END_LO && saw_end_r) begin
        started_nxt = 1'b0;
        saw_end_nxt = 1'b0;
        size_hi_nxt = sccs_pkg::BYTE_ZERO;
        size_lo_nxt = sccs_pkg::BYTE_ZERO;
      end else begin
        saw_end_nxt = 1'b0;
      end
      fwd = reading_r && started_nxt;
    end

    priority if (idle_rep_nxt >= sccs_pkg::IDLE_REPLIES_DONE) begin
      phase_nxt     = sccs_pkg::PH_SHOT;
      idle_rep_nxt  = '0;
      shot_rep_nxt  = '0;
      store_idx_nxt = '0;
      cmd           = sccs_pkg::CMD_SHOT;
    end else if (shot_rep_nxt == sccs_pkg::SHOT_REPLIES_DONE) begin
      phase_nxt        = sccs_pkg::PH_SIZE;
      shot_rep_nxt     = '0;
      size_rep_nxt     = '0;
      capture_size_nxt = 1'b1;
      cmd              = sccs_pkg::CMD_SIZE;
    end else if (size_rep_nxt == sccs_pkg::SIZE_REPLIES_DONE) begin
      size_rep_nxt     = '0;
      phase_nxt        = sccs_pkg::PH_NONE;
      capture_size_nxt = 1'b0;
      reading_nxt      = 1'b1;
      started_nxt      = 1'b0;
      store_idx_nxt    = '0;
      cmd              = sccs_pkg::CMD_READ;
    end else begin
    end

    q_job.fwd      = fwd;
    q_job.fwd_byte = in_data.rx_byte;
    q_job.cmd      = cmd;
    q_job.size_hi  = size_hi_nxt;
    q_job.size_lo  = size_lo_nxt;
    q_push         = accept && (fwd || cmd != sccs_pkg::CMD_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= sccs_pkg::PH_NONE;
      idle_rep_r     <= '0;
      shot_rep_r     <= '0;
      size_rep_r     <= '0;
      store_idx_r    <= '0;
      capture_size_r <= 1'b0;
      reading_r      <= 1'b0;
      started_r      <= 1'b0;
      saw_end_r      <= 1'b0;
      size_hi_r      <= '0;
      size_lo_r      <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      idle_rep_r     <= idle_rep_nxt;
      shot_rep_r     <= shot_rep_nxt;
      size_rep_r     <= size_rep_nxt;
      store_idx_r    <= store_idx_nxt;
      capture_size_r <= capture_size_nxt;
      reading_r      <= reading_nxt;
      started_r      <= started_nxt;
      saw_end_r      <= saw_end_nxt;
      size_hi_r      <= size_hi_nxt;
      size_lo_r      <= size_lo_nxt;
    end
  end

endmodule

/* src/sccs_fifo.sv */
// ----------------------------------------------------------------------------
// sccs_fifo
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module sccs_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sccs_pkg::job_t    push_job,
  input  logic              pop,
  output sccs_pkg::job_t    head_job,
  output sccs_pkg::q_stat_t stat
);

  sccs_pkg::job_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
    stat.full      = (count_r == 2'd2);
    stat.not_empty = (count_r != 2'd0);
    head_job       = entry_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/sccs_back.sv */
// ----------------------------------------------------------------------------
// sccs_back
// Expands one job at a time into result bytes, one per cycle while out is
// not stalled, through an output register.
// ----------------------------------------------------------------------------
module sccs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sccs_pkg::q_stat_t  q_stat,
  input  sccs_pkg::job_t     q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sccs_pkg::out_item_t out_data
);

  logic                job_valid_r, job_valid_nxt;
  sccs_pkg::job_t      job_r;
  logic                fwd_done_r, fwd_done_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  sccs_pkg::out_item_t out_r, out_nxt;
  logic                can_load;
  logic                emit;
  logic                emit_fwd;
  logic                finishing;

  always_comb begin
    can_load = !out_valid_r || !out_stall;
    emit     = job_valid_r && can_load;
    emit_fwd = job_r.fwd && !fwd_done_r;

    if (emit_fwd) begin
      out_nxt.dest    = sccs_pkg::DEST_HOST;
      out_nxt.tx_byte = job_r.fwd_byte;
      out_nxt.last    = (job_r.cmd == sccs_pkg::CMD_NONE);
    end else begin
      out_nxt.dest    = sccs_pkg::DEST_CAMERA;
      out_nxt.tx_byte = sccs_pkg::cmd_byte(job_r.cmd, idx_r, job_r.size_hi, job_r.size_lo);
      out_nxt.last    = (idx_r == sccs_pkg::cmd_last_idx(job_r.cmd));
    end

    finishing = emit && out_nxt.last;
    q_pop     = q_stat.not_empty && (!job_valid_r || finishing);

    out_valid_nxt = emit ? 1'b1 : (can_load ? 1'b0 : out_valid_r);

    job_valid_nxt = job_valid_r;
    fwd_done_nxt  = fwd_done_r;
    idx_nxt       = idx_r;
    priority if (q_pop) begin
      job_valid_nxt = 1'b1;
      fwd_done_nxt  = 1'b0;
      idx_nxt       = '0;
    end else if (finishing) begin
      job_valid_nxt = 1'b0;
    end else if (emit) begin
      if (emit_fwd) begin
        fwd_done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      fwd_done_r  <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      fwd_done_r  <= fwd_done_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/serial_camera_capture_sequencer.sv */
// ----------------------------------------------------------------------------
// serial_camera_capture_sequencer
// Steps a serial camera through one picture capture from host and camera
// bytes, emitting camera commands and forwarding image bytes to the host.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports                       transaction
//   in       input      in_valid in_stall in_data   one received byte
//   out      output     out_valid out_stall out_data one byte to transmit
//
// Cycles: the front end takes one transaction per cycle while the two-entry
// job queue has room. The back end emits one result per cycle while out is
// not stalled. A transaction causes 1 result for a forwarded image byte,
// 5 for a short command, 16 for the image-read command (17 with a forwarded
// byte ahead of it). Transactions with no result cost no back end time.
// Reset (synchronous, rst_n low) clears all phase, counter, queue and
// output control state. A stall on out holds the output register and,
// once the queue fills, raises in_stall.
//
module serial_camera_capture_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sccs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sccs_pkg::out_item_t out_data
);

  // Front to queue: classified jobs
  logic              q_push;
  sccs_pkg::job_t    push_job;
  // Queue to back: head job and fill status
  logic              q_pop;
  sccs_pkg::job_t    head_job;
  sccs_pkg::q_stat_t q_stat;

  // Track phases, count replies, latch the size bytes, classify each byte
  sccs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // Decouple classification from byte emission
  sccs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // Expand each job into result bytes
  sccs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Nothing leaves the block in the cycle after reset
  a_reset_quiet : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Front never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push)
    else $error("job pushed into full queue");

  // Back never pops an empty queue
  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.not_empty)
    else $error("job popped from empty queue");

endmodule
